[design/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg
// shared types and constants of the max-sum sub-rectangle search
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int FLOOR_INIT = 1000000;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_W      = 26;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_COLS = 2'd3;

  typedef struct packed {
    logic load;
    logic start;
    logic row_init;
    logic acc;
    logic head_pop;
    logic cand;
    logic best_upd;
    logic tail_pop;
    logic push;
    logic next_row;
    logic out_load;
  } mss_cmd_t;

  typedef struct packed {
    logic need_hpop;
    logic need_tpop;
    logic last_col;
    logic last_bot;
    logic last_top;
  } mss_status_t;

endpackage

[design/mss_ram.sv]
// ----------------------------------------------------------------------------
// mss_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[design/mss_ctrl.sv]
// ----------------------------------------------------------------------------
// mss_ctrl
// sequencer for loading, the row-pair and column walk, and the result
// ----------------------------------------------------------------------------
module mss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               last_cell_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mss_pkg::mss_status_t status_i,
  output mss_pkg::mss_cmd_t  cmd_o
);
  import mss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ROW, S_RD, S_ACC, S_HEAD, S_HWAIT,
    S_BEST, S_TAIL, S_TWAIT, S_NEXT, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_cell_i) state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d = S_ROW;
      end
      S_ROW: begin
        cmd_o.row_init = 1'b1;
        state_d = S_RD;
      end
      S_RD: state_d = S_ACC;
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        if (status_i.need_hpop) begin
          cmd_o.head_pop = 1'b1;
          state_d = S_HWAIT;
        end else begin
          cmd_o.cand = 1'b1;
          state_d = S_BEST;
        end
      end
      S_HWAIT: state_d = S_HEAD;
      S_BEST: begin
        cmd_o.best_upd = 1'b1;
        state_d = S_TAIL;
      end
      S_TAIL: begin
        if (status_i.need_tpop) begin
          cmd_o.tail_pop = 1'b1;
          state_d = S_TWAIT;
        end else begin
          cmd_o.push = 1'b1;
          state_d = status_i.last_col ? S_NEXT : S_RD;
        end
      end
      S_TWAIT: state_d = S_TAIL;
      S_NEXT: begin
        if (status_i.last_bot && status_i.last_top) begin
          state_d = S_DONE;
        end else begin
          cmd_o.next_row = 1'b1;
          state_d = S_ROW;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/mss_dp.sv]
// ----------------------------------------------------------------------------
// mss_dp
// cell store, column sums, prefix and monotone deque of the search
// ----------------------------------------------------------------------------
module mss_dp #(
  parameter int MAX_DIM   = 32,
  parameter int CELL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [$clog2(MAX_DIM+1)-1:0] n_i,
  input  logic [$clog2(MAX_DIM+1)-1:0] m_i,
  input  logic                         wrap_rows_i,
  input  logic                         wrap_cols_i,
  input  logic signed [CELL_BITS-1:0]  cell_value_i,
  input  mss_pkg::mss_cmd_t            cmd_i,
  output mss_pkg::mss_status_t         status_o,
  output logic signed [mss_pkg::OUT_W-1:0] best_sum_o
);
  import mss_pkg::*;

  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int NC   = MAX_DIM * MAX_DIM;
  localparam int CAW  = (NC > 1) ? $clog2(NC) : 1;
  localparam int LW   = $clog2(NC + 1);
  localparam int CW   = $clog2(2 * MAX_DIM);
  localparam int IW   = $clog2(2 * MAX_DIM + 1);
  localparam int QW   = $clog2(2 * MAX_DIM + 2);
  localparam int DQD  = 2 * MAX_DIM + 1;
  localparam int DQAW = $clog2(DQD);
  localparam int SWN  = CELL_BITS + 2 * $clog2(MAX_DIM + 1) + 3;
  localparam int SW   = (SWN > 27) ? SWN : 27;
  localparam int EW   = IW + SW;

  // load side
  logic [LW-1:0]  load_cnt_q;
  logic [LW-1:0]  total;
  logic           store_we;
  assign total    = LW'(n_i * m_i);
  assign store_we = cmd_i.load && (load_cnt_q < total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else if (cmd_i.start) begin
      load_cnt_q <= '0;
    end else if (store_we) begin
      load_cnt_q <= load_cnt_q + 1'b1;
    end
  end

  // walk counters
  logic [IW-1:0]  rr, cc, last_row;
  logic [CW-1:0]  top_q, bot_q, c_q;
  logic [DW-1:0]  r_q, top_r_q, cm_q;
  logic [CAW-1:0] rowbase_q;
  logic [QW-1:0]  head_q, tail_q;
  logic signed [SW-1:0] prefix_q, cand_q, best_q;
  logic signed [OUT_W-1:0] best_out_q;

  assign rr = wrap_rows_i ? IW'({n_i, 1'b0}) : IW'(n_i);
  assign cc = wrap_cols_i ? IW'({m_i, 1'b0}) : IW'(m_i);

  always_comb begin
    if (IW'(top_q) + IW'(n_i) - 1'b1 > rr - 1'b1) last_row = rr - 1'b1;
    else last_row = IW'(top_q) + IW'(n_i) - 1'b1;
  end

  // memories
  logic [CAW-1:0]       cell_raddr;
  logic [CELL_BITS-1:0] cell_rd;
  logic [SW-1:0]        col_rd;
  logic signed [SW-1:0] col_new;
  logic [EW-1:0]        hd_rd, tl_rd, dq_wdata;
  logic [DQAW-1:0]      dq_waddr;
  logic                 dq_we;
  logic [QW-1:0]        tail_m1;
  logic [IW-1:0]        k;

  assign cell_raddr = rowbase_q + CAW'(cm_q);
  assign tail_m1    = tail_q - 1'b1;
  assign k          = IW'(c_q) + 1'b1;

  mss_ram #(.WIDTH(CELL_BITS), .DEPTH(NC)) u_cells (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (load_cnt_q[CAW-1:0]),
    .wdata_i (cell_value_i),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rd)
  );

  assign col_new = ((bot_q == top_q) ? SW'(0) : $signed(col_rd))
                 + SW'($signed(cell_rd));

  mss_ram #(.WIDTH(SW), .DEPTH(2 * MAX_DIM)) u_colsum (
    .clk_i   (clk_i),
    .we_i    (cmd_i.acc),
    .waddr_i (c_q),
    .wdata_i (col_new),
    .raddr_i (c_q),
    .rdata_o (col_rd)
  );

  assign dq_we    = cmd_i.row_init | cmd_i.push;
  assign dq_waddr = cmd_i.row_init ? DQAW'(0) : tail_q[DQAW-1:0];
  assign dq_wdata = cmd_i.row_init ? EW'(0) : {k, prefix_q};

  mss_ram #(.WIDTH(EW), .DEPTH(DQD)) u_dq_head (
    .clk_i   (clk_i),
    .we_i    (dq_we),
    .waddr_i (dq_waddr),
    .wdata_i (dq_wdata),
    .raddr_i (head_q[DQAW-1:0]),
    .rdata_o (hd_rd)
  );

  mss_ram #(.WIDTH(EW), .DEPTH(DQD)) u_dq_tail (
    .clk_i   (clk_i),
    .we_i    (dq_we),
    .waddr_i (dq_waddr),
    .wdata_i (dq_wdata),
    .raddr_i (tail_m1[DQAW-1:0]),
    .rdata_o (tl_rd)
  );

  logic [IW-1:0]        hd_idx;
  logic signed [SW-1:0] hd_p, tl_p;
  assign hd_idx = hd_rd[EW-1:SW];
  assign hd_p   = $signed(hd_rd[SW-1:0]);
  assign tl_p   = $signed(tl_rd[SW-1:0]);

  assign status_o.need_hpop = (head_q < tail_q) && ((k - hd_idx) > IW'(m_i));
  assign status_o.need_tpop = (tail_q > head_q) && (tl_p >= prefix_q);
  assign status_o.last_col  = (IW'(c_q) == cc - 1'b1);
  assign status_o.last_bot  = (IW'(bot_q) == last_row);
  assign status_o.last_top  = (IW'(top_q) == rr - 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      best_q  <= SW'(-FLOOR_INIT);
      top_q   <= '0;
      bot_q   <= '0;
      r_q     <= '0;
      top_r_q <= '0;
    end
    if (cmd_i.row_init) begin
      rowbase_q <= CAW'(r_q * m_i);
      head_q    <= '0;
      tail_q    <= QW'(1);
      prefix_q  <= '0;
      c_q       <= '0;
      cm_q      <= '0;
    end
    if (cmd_i.acc) prefix_q <= prefix_q + col_new;
    if (cmd_i.head_pop) head_q <= head_q + 1'b1;
    if (cmd_i.cand) cand_q <= prefix_q - hd_p;
    if (cmd_i.best_upd && (cand_q > best_q)) best_q <= cand_q;
    if (cmd_i.tail_pop) tail_q <= tail_m1;
    if (cmd_i.push) begin
      tail_q <= tail_q + 1'b1;
      c_q    <= c_q + 1'b1;
      cm_q   <= (cm_q == m_i - 1'b1) ? DW'(0) : cm_q + 1'b1;
    end
    if (cmd_i.next_row) begin
      if (status_o.last_bot) begin
        top_q   <= top_q + 1'b1;
        bot_q   <= top_q + 1'b1;
        top_r_q <= (top_r_q == n_i - 1'b1) ? DW'(0) : top_r_q + 1'b1;
        r_q     <= (top_r_q == n_i - 1'b1) ? DW'(0) : top_r_q + 1'b1;
      end else begin
        bot_q <= bot_q + 1'b1;
        r_q   <= (r_q == n_i - 1'b1) ? DW'(0) : r_q + 1'b1;
      end
    end
    if (cmd_i.out_load) best_out_q <= best_q[OUT_W-1:0];
  end

  assign best_sum_o = best_out_q;

endmodule

[design/max_sum_subrectangle_wrap.sv]
// loading: one cell per cycle while in_valid_i is high; after the last cell the
// sequencer walks every row pair and every column, each column step passing the
// read, accumulate, head, best and tail states (and a wait per deque pop), with
// S_ROW and S_NEXT per row pair, for the registered column-sum and deque reads
// throughput: one grid at a time; a new grid loads while the result waits
// reset: control state and configuration cleared at once, no clearing pass
// ----------------------------------------------------------------------------
// max_sum_subrectangle_wrap
// largest sum of any sub-rectangle of a grid, with optional row/column wrap
// ----------------------------------------------------------------------------
module max_sum_subrectangle_wrap #(
  parameter int MAX_DIM   = 32,
  parameter int CELL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mss_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [CELL_BITS-1:0]    cell_value_i,
  input  logic                           last_cell_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [mss_pkg::OUT_W-1:0] best_sum_o
);
  import mss_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0] num_rows_q, num_cols_q;
  logic             wrap_rows_q, wrap_cols_q;
  logic [DW-1:0]    n, m;
  mss_cmd_t         cmd;
  mss_status_t      status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q  <= CFG_W'(32);
      num_cols_q  <= CFG_W'(32);
      wrap_rows_q <= 1'b0;
      wrap_cols_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NUM_ROWS:  num_rows_q  <= cfg_data_i;
        REG_NUM_COLS:  num_cols_q  <= cfg_data_i;
        REG_WRAP_ROWS: wrap_rows_q <= cfg_data_i[0];
        REG_WRAP_COLS: wrap_cols_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_rows_q == '0) n = DW'(1);
    else if (int'(num_rows_q) > MAX_DIM) n = DW'(MAX_DIM);
    else n = DW'(num_rows_q);
    if (num_cols_q == '0) m = DW'(1);
    else if (int'(num_cols_q) > MAX_DIM) m = DW'(MAX_DIM);
    else m = DW'(num_cols_q);
  end

  mss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_cell_i (last_cell_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mss_dp #(.MAX_DIM(MAX_DIM), .CELL_BITS(CELL_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_i          (n),
    .m_i          (m),
    .wrap_rows_i  (wrap_rows_q),
    .wrap_cols_i  (wrap_cols_q),
    .cell_value_i (cell_value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .best_sum_o   (best_sum_o)
  );

endmodule
